// ----- src/tnap_pkg.sv -----
// package: widths, sideband type and constants of the triangle normal, area and plane unit
`timescale 1ns / 1ps
package tnap_pkg;

    localparam int COORD_W = 32;
    localparam int EDGE_W  = 33;
    localparam int PROD_W  = 66;
    localparam int CROSS_W = 67;
    localparam int MAG_W   = 66;
    localparam int HI_W    = MAG_W - 32;
    localparam int LO_W    = 32;
    localparam int HH_W    = 2 * HI_W;
    localparam int HL_W    = HI_W + LO_W;
    localparam int LL_W    = 2 * LO_W;
    localparam int SUM_W   = 132;
    localparam int ROOT_W  = 96;
    localparam int REM_W   = ROOT_W + 4;
    localparam int QUO_W   = 31;
    localparam int NUM_SHIFT = 61;
    localparam int NUM_W   = MAG_W + NUM_SHIFT + 1;
    localparam int DEN_W   = ROOT_W + 1;
    localparam int NORM_W  = 32;
    localparam int AREA_W  = 50;
    localparam int AREA_LSB = 48;
    localparam int DIST_W  = 33;
    localparam int DOT_W   = 66;
    localparam int FRAC_SHIFT = 30;
    localparam int WIDE_DIST_W = DOT_W - FRAC_SHIFT;

    localparam logic signed [DOT_W-1:0] RND_BIAS = 66'sd536870912;
    localparam logic signed [WIDE_DIST_W-1:0] DIST_HI = 36'sd4294967295;
    localparam logic signed [WIDE_DIST_W-1:0] DIST_LO = -36'sd4294967296;

    typedef struct packed {
        logic [2:0][MAG_W-1:0]   mag;
        logic [2:0]              neg;
        logic [2:0][COORD_W-1:0] coord;
        logic                    deg;
    } side_t;

endpackage

// ----- src/tnap_in_if.sv -----
// interface: vertex transaction channel
`timescale 1ns / 1ps
interface tnap_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] a_x;
    logic signed [31:0] a_y;
    logic signed [31:0] a_z;
    logic signed [31:0] b_x;
    logic signed [31:0] b_y;
    logic signed [31:0] b_z;
    logic signed [31:0] c_x;
    logic signed [31:0] c_y;
    logic signed [31:0] c_z;

    modport source (output valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, input ready);
    modport sink (input valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, output ready);
    modport mon (input valid, ready, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z);
endinterface

// ----- src/tnap_out_if.sv -----
// interface: result transaction channel
`timescale 1ns / 1ps
interface tnap_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] normal_x;
    logic signed [31:0] normal_y;
    logic signed [31:0] normal_z;
    logic [49:0]        tri_area;
    logic signed [32:0] plane_distance;
    logic               degenerate;

    modport source (output valid, normal_x, normal_y, normal_z, tri_area, plane_distance,
                    degenerate, input ready);
    modport sink (input valid, normal_x, normal_y, normal_z, tri_area, plane_distance,
                  degenerate, output ready);
    modport mon (input valid, ready, normal_x, normal_y, normal_z, tri_area, plane_distance,
                 degenerate);
endinterface

// ----- src/tnap_isqrt_pipe.sv -----
// pipelined integer square root, one root bit per stage
`timescale 1ns / 1ps
module tnap_isqrt_pipe (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           en,
    input  logic                           in_valid,
    input  logic [tnap_pkg::SUM_W-1:0]     in_rad,
    input  tnap_pkg::side_t                in_side,
    output logic                           out_valid,
    output logic [tnap_pkg::ROOT_W-1:0]    out_root,
    output tnap_pkg::side_t                out_side
);
    localparam int STAGES = tnap_pkg::ROOT_W;
    localparam int SUM_W  = tnap_pkg::SUM_W;
    localparam int REM_W  = tnap_pkg::REM_W;
    localparam int ROOT_W = tnap_pkg::ROOT_W;

    logic                  valid_reg [STAGES];
    logic [SUM_W-1:0]      rad_reg   [STAGES];
    logic [REM_W-1:0]      rem_reg   [STAGES];
    logic [ROOT_W-1:0]     root_reg  [STAGES];
    tnap_pkg::side_t       side_reg  [STAGES];

    for (genvar k = 0; k < STAGES; k++)
    begin : g_step
        logic              v_src;
        logic [SUM_W-1:0]  rad_src;
        logic [REM_W-1:0]  rem_src;
        logic [ROOT_W-1:0] root_src;
        tnap_pkg::side_t   side_src;
        logic [REM_W-1:0]  rem_x;
        logic [REM_W-1:0]  trial;
        logic [REM_W-1:0]  rem_next;
        logic [ROOT_W-1:0] root_next;
        logic [SUM_W-1:0]  rad_next;

        if (k == 0)
        begin : g_first
            assign v_src    = in_valid;
            assign rad_src  = in_rad;
            assign rem_src  = '0;
            assign root_src = '0;
            assign side_src = in_side;
        end
        else
        begin : g_rest
            assign v_src    = valid_reg[k-1];
            assign rad_src  = rad_reg[k-1];
            assign rem_src  = rem_reg[k-1];
            assign root_src = root_reg[k-1];
            assign side_src = side_reg[k-1];
        end

        always_comb
        begin
            rem_x    = {rem_src[REM_W-3:0], rad_src[SUM_W-1 -: 2]};
            trial    = {{(REM_W-ROOT_W-2){1'b0}}, root_src, 2'b01};
            rad_next = rad_src << 2;
            if (rem_x >= trial)
            begin
                rem_next  = rem_x - trial;
                root_next = {root_src[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_x;
                root_next = {root_src[ROOT_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[k] <= 1'b0;
            else if (en)
                valid_reg[k] <= v_src;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rad_reg[k]  <= rad_next;
                rem_reg[k]  <= rem_next;
                root_reg[k] <= root_next;
                side_reg[k] <= side_src;
            end
        end
    end

    assign out_valid = valid_reg[STAGES-1];
    assign out_root  = root_reg[STAGES-1];
    assign out_side  = side_reg[STAGES-1];
endmodule

// ----- src/tnap_div_pipe.sv -----
// three-lane pipelined restoring divider, one quotient bit per stage
`timescale 1ns / 1ps
module tnap_div_pipe (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                en,
    input  logic                                in_valid,
    input  logic [tnap_pkg::ROOT_W-1:0]         in_root,
    input  tnap_pkg::side_t                     in_side,
    output logic                                out_valid,
    output logic [2:0][tnap_pkg::QUO_W-1:0]     out_quo,
    output logic [tnap_pkg::DEN_W-1:0]          out_den,
    output tnap_pkg::side_t                     out_side
);
    localparam int STAGES = tnap_pkg::QUO_W;
    localparam int QUO_W  = tnap_pkg::QUO_W;
    localparam int DEN_W  = tnap_pkg::DEN_W;
    localparam int NUM_W  = tnap_pkg::NUM_W;
    localparam int ROOT_W = tnap_pkg::ROOT_W;

    logic                         pv_reg;
    logic [2:0][DEN_W-1:0]        prem_reg;
    logic [2:0][QUO_W-1:0]        plow_reg;
    logic [DEN_W-1:0]             pden_reg;
    tnap_pkg::side_t              pside_reg;
    logic [2:0][DEN_W-1:0]        prem_next;
    logic [2:0][QUO_W-1:0]        plow_next;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            logic [NUM_W-1:0] num;
            num = {1'b0, in_side.mag[i], {tnap_pkg::NUM_SHIFT{1'b0}}}
                + {{(NUM_W-ROOT_W){1'b0}}, in_root};
            prem_next[i] = num[NUM_W-1:QUO_W];
            plow_next[i] = num[QUO_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pv_reg <= 1'b0;
        else if (en)
            pv_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prem_reg  <= prem_next;
            plow_reg  <= plow_next;
            pden_reg  <= {in_root, 1'b0};
            pside_reg <= in_side;
        end
    end

    logic                   valid_reg [STAGES];
    logic [2:0][DEN_W-1:0]  rem_reg   [STAGES];
    logic [2:0][QUO_W-1:0]  low_reg   [STAGES];
    logic [2:0][QUO_W-1:0]  quo_reg   [STAGES];
    logic [DEN_W-1:0]       den_reg   [STAGES];
    tnap_pkg::side_t        side_reg  [STAGES];

    for (genvar k = 0; k < STAGES; k++)
    begin : g_step
        logic                  v_src;
        logic [2:0][DEN_W-1:0] rem_src;
        logic [2:0][QUO_W-1:0] low_src;
        logic [2:0][QUO_W-1:0] quo_src;
        logic [DEN_W-1:0]      den_src;
        tnap_pkg::side_t       side_src;
        logic [2:0][DEN_W-1:0] rem_next;
        logic [2:0][QUO_W-1:0] low_next;
        logic [2:0][QUO_W-1:0] quo_next;

        if (k == 0)
        begin : g_first
            assign v_src    = pv_reg;
            assign rem_src  = prem_reg;
            assign low_src  = plow_reg;
            assign quo_src  = '0;
            assign den_src  = pden_reg;
            assign side_src = pside_reg;
        end
        else
        begin : g_rest
            assign v_src    = valid_reg[k-1];
            assign rem_src  = rem_reg[k-1];
            assign low_src  = low_reg[k-1];
            assign quo_src  = quo_reg[k-1];
            assign den_src  = den_reg[k-1];
            assign side_src = side_reg[k-1];
        end

        always_comb
        begin
            for (int i = 0; i < 3; i++)
            begin
                logic [DEN_W:0] rem_x;
                logic [DEN_W:0] diff;
                rem_x = {rem_src[i], low_src[i][QUO_W-1]};
                diff  = rem_x - {1'b0, den_src};
                low_next[i] = low_src[i] << 1;
                if (rem_x >= {1'b0, den_src})
                begin
                    rem_next[i] = diff[DEN_W-1:0];
                    quo_next[i] = {quo_src[i][QUO_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next[i] = rem_x[DEN_W-1:0];
                    quo_next[i] = {quo_src[i][QUO_W-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[k] <= 1'b0;
            else if (en)
                valid_reg[k] <= v_src;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= rem_next;
                low_reg[k]  <= low_next;
                quo_reg[k]  <= quo_next;
                den_reg[k]  <= den_src;
                side_reg[k] <= side_src;
            end
        end
    end

    assign out_valid = valid_reg[STAGES-1];
    assign out_quo   = quo_reg[STAGES-1];
    assign out_den   = den_reg[STAGES-1];
    assign out_side  = side_reg[STAGES-1];
endmodule

// ----- src/triangle_normal_area_plane_unit.sv -----
// top level: triangle unit normal, area and plane distance pipeline
// Takes one triangle per clock unless the result side stalls and returns one result per
// triangle, in order. A taken triangle passes the registers for edges, cross product and
// its squared magnitude, the square-root pipeline (one root bit per stage), the three-lane
// divider (one quotient bit per stage) and the registers for the normal sign, the dot
// product and the output. A stall at the result side holds the whole pipeline, so
// the vertex side is ready whenever the output register is empty or being taken. A triangle
// with a zero cross product returns zero normal, area and distance with degenerate set.
`timescale 1ns / 1ps
module triangle_normal_area_plane_unit (
    input  logic         clk,
    input  logic         rst_n,
    tnap_in_if.sink      vertices,
    tnap_out_if.source   results
);
    localparam int COORD_W = tnap_pkg::COORD_W;
    localparam int EDGE_W  = tnap_pkg::EDGE_W;
    localparam int PROD_W  = tnap_pkg::PROD_W;
    localparam int CROSS_W = tnap_pkg::CROSS_W;
    localparam int MAG_W   = tnap_pkg::MAG_W;
    localparam int SUM_W   = tnap_pkg::SUM_W;
    localparam int NORM_W  = tnap_pkg::NORM_W;
    localparam int DOT_W   = tnap_pkg::DOT_W;
    localparam int AREA_W  = tnap_pkg::AREA_W;
    localparam int DIST_W  = tnap_pkg::DIST_W;
    localparam int QUO_W   = tnap_pkg::QUO_W;

    logic en;
    logic out_valid_reg;

    assign en             = !out_valid_reg || results.ready;
    assign vertices.ready = en;

    // edge vectors
    logic                           v0_reg;
    logic signed [2:0][EDGE_W-1:0]  e_reg, f_reg;
    logic [2:0][COORD_W-1:0]        a0_reg;
    logic [2:0][EDGE_W-1:0]         e_next, f_next;

    always_comb
    begin
        e_next[0] = EDGE_W'(vertices.b_x) - EDGE_W'(vertices.a_x);
        e_next[1] = EDGE_W'(vertices.b_y) - EDGE_W'(vertices.a_y);
        e_next[2] = EDGE_W'(vertices.b_z) - EDGE_W'(vertices.a_z);
        f_next[0] = EDGE_W'(vertices.c_x) - EDGE_W'(vertices.a_x);
        f_next[1] = EDGE_W'(vertices.c_y) - EDGE_W'(vertices.a_y);
        f_next[2] = EDGE_W'(vertices.c_z) - EDGE_W'(vertices.a_z);
    end

    // cross product terms
    logic                       v1_reg;
    logic [5:0][PROD_W-1:0]     p_reg;
    logic [2:0][COORD_W-1:0]    a1_reg;
    logic [5:0][PROD_W-1:0]     p_next;

    always_comb
    begin
        p_next[0] = PROD_W'($signed(e_reg[1]) * $signed(f_reg[2]));
        p_next[1] = PROD_W'($signed(e_reg[2]) * $signed(f_reg[1]));
        p_next[2] = PROD_W'($signed(e_reg[2]) * $signed(f_reg[0]));
        p_next[3] = PROD_W'($signed(e_reg[0]) * $signed(f_reg[2]));
        p_next[4] = PROD_W'($signed(e_reg[0]) * $signed(f_reg[1]));
        p_next[5] = PROD_W'($signed(e_reg[1]) * $signed(f_reg[0]));
    end

    // cross components as sign and magnitude
    tnap_pkg::side_t   s2_reg;
    logic              v2_reg;
    tnap_pkg::side_t   s2_next;

    always_comb
    begin
        s2_next       = '0;
        s2_next.coord = a1_reg;
        for (int i = 0; i < 3; i++)
        begin
            logic signed [CROSS_W-1:0] cr;
            logic signed [CROSS_W-1:0] neg_cr;
            cr = CROSS_W'($signed(p_reg[2*i])) - CROSS_W'($signed(p_reg[2*i+1]));
            neg_cr = -cr;
            s2_next.neg[i] = cr[CROSS_W-1];
            s2_next.mag[i] = cr[CROSS_W-1] ? neg_cr[MAG_W-1:0] : cr[MAG_W-1:0];
        end
        s2_next.deg = (s2_next.mag == '0);
    end

    // squares in partial products
    logic                                  v3_reg;
    tnap_pkg::side_t                       s3_reg;
    logic [2:0][tnap_pkg::HH_W-1:0]        hh_reg;
    logic [2:0][tnap_pkg::HL_W-1:0]        hl_reg;
    logic [2:0][tnap_pkg::LL_W-1:0]        ll_reg;
    logic [2:0][tnap_pkg::HH_W-1:0]        hh_next;
    logic [2:0][tnap_pkg::HL_W-1:0]        hl_next;
    logic [2:0][tnap_pkg::LL_W-1:0]        ll_next;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            logic [tnap_pkg::HI_W-1:0] hi;
            logic [tnap_pkg::LO_W-1:0] lo;
            hi = s2_reg.mag[i][MAG_W-1:tnap_pkg::LO_W];
            lo = s2_reg.mag[i][tnap_pkg::LO_W-1:0];
            hh_next[i] = hi * hi;
            hl_next[i] = hi * {{(tnap_pkg::HI_W-tnap_pkg::LO_W){1'b0}}, lo};
            ll_next[i] = lo * lo;
        end
    end

    logic                     v4_reg;
    tnap_pkg::side_t          s4_reg;
    logic [2:0][SUM_W-1:0]    sq_reg;
    logic [2:0][SUM_W-1:0]    sq_next;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            sq_next[i] = (SUM_W'(hh_reg[i]) << (2 * tnap_pkg::LO_W))
                       + (SUM_W'(hl_reg[i]) << (tnap_pkg::LO_W + 1))
                       + SUM_W'(ll_reg[i]);
    end

    logic                v5_reg;
    tnap_pkg::side_t     s5_reg;
    logic [SUM_W-1:0]    ssum_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else if (en)
        begin
            v0_reg <= vertices.valid;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e_reg    <= e_next;
            f_reg    <= f_next;
            a0_reg   <= {vertices.a_z, vertices.a_y, vertices.a_x};
            p_reg    <= p_next;
            a1_reg   <= a0_reg;
            s2_reg   <= s2_next;
            s3_reg   <= s2_reg;
            hh_reg   <= hh_next;
            hl_reg   <= hl_next;
            ll_reg   <= ll_next;
            s4_reg   <= s3_reg;
            sq_reg   <= sq_next;
            s5_reg   <= s4_reg;
            ssum_reg <= sq_reg[0] + sq_reg[1] + sq_reg[2];
        end
    end

    // magnitude with 30 fraction bits
    logic                            sq_valid;
    logic [tnap_pkg::ROOT_W-1:0]     sq_root;
    tnap_pkg::side_t                 sq_side;

    tnap_isqrt_pipe u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v5_reg),
        .in_rad    (ssum_reg),
        .in_side   (s5_reg),
        .out_valid (sq_valid),
        .out_root  (sq_root),
        .out_side  (sq_side)
    );

    // normal magnitudes
    logic                            dv_valid;
    logic [2:0][QUO_W-1:0]           dv_quo;
    logic [tnap_pkg::DEN_W-1:0]      dv_den;
    tnap_pkg::side_t                 dv_side;

    tnap_div_pipe u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sq_valid),
        .in_root   (sq_root),
        .in_side   (sq_side),
        .out_valid (dv_valid),
        .out_quo   (dv_quo),
        .out_den   (dv_den),
        .out_side  (dv_side)
    );

    // signed normal, area
    logic                           vn_reg;
    logic [2:0][NORM_W-1:0]         nrm_reg;
    logic [2:0][COORD_W-1:0]        an_reg;
    logic [AREA_W-1:0]              arn_reg;
    logic                           dgn_reg;
    logic [2:0][NORM_W-1:0]         nrm_next;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            logic [NORM_W-1:0] q;
            q = {1'b0, dv_quo[i]};
            nrm_next[i] = dv_side.neg[i] ? -q : q;
        end
    end

    // dot products
    logic                             vp_reg;
    logic [2:0][NORM_W-1:0]           nrp_reg;
    logic [2:0][COORD_W+NORM_W-1:0]   dp_reg;
    logic [AREA_W-1:0]                arp_reg;
    logic                             dgp_reg;
    logic [2:0][COORD_W+NORM_W-1:0]   dp_next;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            dp_next[i] = (COORD_W+NORM_W)'($signed(an_reg[i]) * $signed(nrm_reg[i]));
    end

    // rounding, saturation, degenerate masking
    logic signed [DOT_W-1:0]                  acc;
    logic signed [DOT_W-1:0]                  rnd;
    logic signed [tnap_pkg::WIDE_DIST_W-1:0]  dist_w;
    logic [DIST_W-1:0]                        dist_sat;

    always_comb
    begin
        acc    = DOT_W'($signed(dp_reg[0])) + DOT_W'($signed(dp_reg[1]))
               + DOT_W'($signed(dp_reg[2]));
        rnd    = acc + tnap_pkg::RND_BIAS;
        dist_w = tnap_pkg::WIDE_DIST_W'(rnd >>> tnap_pkg::FRAC_SHIFT);
        priority if (dist_w > tnap_pkg::DIST_HI)
            dist_sat = tnap_pkg::DIST_HI[DIST_W-1:0];
        else if (dist_w < tnap_pkg::DIST_LO)
            dist_sat = tnap_pkg::DIST_LO[DIST_W-1:0];
        else
            dist_sat = dist_w[DIST_W-1:0];
    end

    logic [2:0][NORM_W-1:0]   nrm_out_reg;
    logic [AREA_W-1:0]        area_out_reg;
    logic [DIST_W-1:0]        dist_out_reg;
    logic                     deg_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vn_reg        <= 1'b0;
            vp_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vn_reg        <= dv_valid;
            vp_reg        <= vn_reg;
            out_valid_reg <= vp_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nrm_reg <= nrm_next;
            an_reg  <= dv_side.coord;
            arn_reg <= {{(AREA_W-(tnap_pkg::DEN_W-tnap_pkg::AREA_LSB)){1'b0}},
                        dv_den[tnap_pkg::DEN_W-1:tnap_pkg::AREA_LSB]};
            dgn_reg <= dv_side.deg;
            nrp_reg <= nrm_reg;
            dp_reg  <= dp_next;
            arp_reg <= arn_reg;
            dgp_reg <= dgn_reg;
            nrm_out_reg  <= dgp_reg ? '0 : nrp_reg;
            area_out_reg <= dgp_reg ? '0 : arp_reg;
            dist_out_reg <= dgp_reg ? '0 : dist_sat;
            deg_out_reg  <= dgp_reg;
        end
    end

    assign results.valid          = out_valid_reg;
    assign results.normal_x       = nrm_out_reg[0];
    assign results.normal_y       = nrm_out_reg[1];
    assign results.normal_z       = nrm_out_reg[2];
    assign results.tri_area       = area_out_reg;
    assign results.plane_distance = dist_out_reg;
    assign results.degenerate     = deg_out_reg;
endmodule

// ----- src/tnap_checker.sv -----
// checker: port-level properties of the triangle normal, area and plane unit
`timescale 1ns / 1ps
module tnap_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                in_ready,
    input logic                                out_valid,
    input logic                                out_ready,
    input logic signed [tnap_pkg::NORM_W-1:0]  normal_x,
    input logic signed [tnap_pkg::NORM_W-1:0]  normal_y,
    input logic signed [tnap_pkg::NORM_W-1:0]  normal_z,
    input logic [tnap_pkg::AREA_W-1:0]         tri_area,
    input logic signed [tnap_pkg::DIST_W-1:0]  plane_distance,
    input logic                                degenerate
);
    // degenerate results carry all-zero fields
    a_deg_zero : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && degenerate |->
            normal_x == 32'sd0 && normal_y == 32'sd0 &&
            normal_z == 32'sd0 && tri_area == 50'd0 &&
            plane_distance == 33'sd0)
        else $error("degenerate transaction with nonzero fields");

    // unit normal components stay within one
    a_norm_range : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |->
            normal_x <= 32'sd1073741824 && normal_x >= -32'sd1073741824 &&
            normal_y <= 32'sd1073741824 && normal_y >= -32'sd1073741824 &&
            normal_z <= 32'sd1073741824 && normal_z >= -32'sd1073741824)
        else $error("normal component out of range");

    // a non-degenerate triangle has a nonzero normal
    a_norm_nonzero : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !degenerate |->
            normal_x != 32'sd0 || normal_y != 32'sd0 || normal_z != 32'sd0)
        else $error("zero normal on non-degenerate transaction");

    // input side is ready whenever the output register can move
    a_ready_flow : assert property (@(posedge clk) disable iff (!rst_n)
        in_ready == (!out_valid || out_ready))
        else $error("vertex ready does not follow result side");

    // a stalled result stays valid and holds its area and distance
    a_out_hold : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=>
            out_valid && $stable(tri_area) && $stable(plane_distance))
        else $error("stalled result changed");
endmodule

bind triangle_normal_area_plane_unit tnap_checker u_tnap_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_ready       (vertices.ready),
    .out_valid      (results.valid),
    .out_ready      (results.ready),
    .normal_x       (results.normal_x),
    .normal_y       (results.normal_y),
    .normal_z       (results.normal_z),
    .tri_area       (results.tri_area),
    .plane_distance (results.plane_distance),
    .degenerate     (results.degenerate)
);
